>>> src/mspq_pkg.sv
package mspq_pkg;

    // Fixed field widths on the stream ports
    localparam int TYPE_W     = 2;
    localparam int IDX_W      = 3;
    localparam int IN_KEY_W   = 64;
    localparam int STATUS_W   = 2;
    localparam int FILL_OUT_W = 5;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 72;

    // Request kinds
    localparam logic [TYPE_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_POP   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_NOP   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [IN_KEY_W-1:0]   t_key_out;
    typedef logic [FILL_OUT_W-1:0] t_fill_out;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // Per-cell command from the sequencer
    typedef struct packed {
        logic push;  // insert the request key into the addressed queue
        logic live;  // this slot lies below the queue's fill
    } t_cell_ctl;

endpackage

>>> src/multi_sorted_priority_queue_top.sv
// Several independent priority queues of unsigned keys, each kept sorted.
// Input channel (i_s_*): one request word per handshake. tuser carries the
// request kind (push, pop smallest, clear, nop); tdata carries the queue index
// and the key. A pop returns the smallest key of the queue, the oldest
// first among equal keys. A push to a full queue is dropped with status
// full; a pop from an empty queue returns status empty.
// Output channel (o_m_*): exactly one result word per request, in order.
// tuser carries the status; tdata the popped key and the fill afterwards.
// A new request is taken only in the idle state, so not before the last one
// completes. A request first reads every slot cell's queue RAM at the
// addressed queue, then in the execute state all cells compare against the
// new key in parallel and shift or insert.
// A finished result waits in the output register; a new request is still
// taken meanwhile, and its execute state holds until that register frees.
// Reset clears all fill counts, so every queue starts empty; stored keys
// need no clearing. The input tready stays low while reset is held.
// No configuration registers.
module multi_sorted_priority_queue_top #(
    parameter int QUEUE_COUNT = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // [2:0] queue_index, [66:3] item_key, rest zero
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [63:0] popped_key, [68:64] fill_after, rest zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(QUEUE_DEPTH);

    typedef logic [QW-1:0] t_qaddr;
    typedef logic [SW-1:0] t_slot;
    typedef logic [FW-1:0] t_fill;

    mspq_pkg::t_state r_state, n_state;

    logic [mspq_pkg::TYPE_W-1:0] r_type;
    t_qaddr                      r_q;
    logic                        r_q_ok;
    logic [KEY_BITS-1:0]         r_key;

    t_fill r_fill [QUEUE_COUNT];

    logic                          r_out_valid, n_out_valid;
    logic [mspq_pkg::IN_KEY_W-1:0] r_out_key, n_out_key;
    logic [mspq_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [FW-1:0]                 r_out_fill, n_out_fill;

    logic   w_s_accept;
    logic   w_done;
    t_qaddr w_in_q;
    t_qaddr w_rd_addr;
    t_fill  w_cur_fill;
    logic   w_full;
    logic   w_do_push;
    logic   w_fill_we;
    t_fill  w_fill_new;
    t_slot  w_pop_sel;

    logic [KEY_BITS-1:0] w_cell_key [QUEUE_DEPTH];
    logic                w_cell_gt  [QUEUE_DEPTH];

    assign o_s_tready = i_rst_n && (r_state == mspq_pkg::S_IDLE);
    assign w_s_accept = i_s_tvalid && o_s_tready;
    assign w_in_q     = t_qaddr'(i_s_tdata[mspq_pkg::IDX_W-1:0]);

    // The execute state completes once the output register is free
    assign w_done = (r_state == mspq_pkg::S_EXEC) && (!r_out_valid || i_m_tready);

    // Read every cell at the incoming queue, then keep the address
    assign w_rd_addr = (r_state == mspq_pkg::S_IDLE) ? w_in_q : r_q;

    assign w_cur_fill = r_fill[r_q];
    assign w_full     = (32'(w_cur_fill) >= QUEUE_DEPTH);
    assign w_do_push  = w_done && r_q_ok && (r_type == mspq_pkg::REQ_PUSH) && !w_full;
    assign w_pop_sel  = t_slot'(w_cur_fill - t_fill'(1));

    // Row of slot cells, slot 0 holds the largest key
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        mspq_pkg::t_cell_ctl w_ctl;
        logic                w_prev_gt;
        logic [KEY_BITS-1:0] w_prev_key;

        assign w_ctl.push = w_do_push;
        assign w_ctl.live = (32'(w_cur_fill) > g);

        if (g == 0) begin : g_head
            assign w_prev_gt  = 1'b1;
            assign w_prev_key = r_key;
        end else begin : g_link
            assign w_prev_gt  = w_cell_gt[g-1];
            assign w_prev_key = w_cell_key[g-1];
        end

        mspq_cell #(
            .QUEUE_COUNT(QUEUE_COUNT),
            .KEY_BITS   (KEY_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rd_addr (w_rd_addr),
            .i_wr_addr (r_q),
            .i_ctl     (w_ctl),
            .i_key     (r_key),
            .i_prev_gt (w_prev_gt),
            .i_prev_key(w_prev_key),
            .o_key     (w_cell_key[g]),
            .o_gt      (w_cell_gt[g])
        );
    end

    // Work out the result and the new fill of the addressed queue
    always_comb begin
        n_out_key    = '0;
        n_out_status = mspq_pkg::ST_OK;
        n_out_fill   = '0;
        w_fill_we    = 1'b0;
        w_fill_new   = w_cur_fill;
        if (r_q_ok) begin
            case (r_type)
                mspq_pkg::REQ_PUSH: begin
                    if (w_full) begin
                        n_out_status = mspq_pkg::ST_FULL;
                        n_out_fill   = w_cur_fill;
                    end else begin
                        w_fill_we  = 1'b1;
                        w_fill_new = w_cur_fill + t_fill'(1);
                        n_out_fill = w_fill_new;
                    end
                end
                mspq_pkg::REQ_POP: begin
                    if (w_cur_fill == '0) begin
                        n_out_status = mspq_pkg::ST_EMPTY;
                    end else begin
                        w_fill_we  = 1'b1;
                        w_fill_new = w_cur_fill - t_fill'(1);
                        n_out_fill = w_fill_new;
                        n_out_key  = mspq_pkg::t_key_out'(w_cell_key[w_pop_sel]);
                    end
                end
                mspq_pkg::REQ_CLEAR: begin
                    w_fill_we  = 1'b1;
                    w_fill_new = '0;
                end
                default: begin
                    n_out_fill = w_cur_fill;
                end
            endcase
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mspq_pkg::S_IDLE: if (w_s_accept) n_state = mspq_pkg::S_EXEC;
            mspq_pkg::S_EXEC: if (w_done) n_state = mspq_pkg::S_IDLE;
            default:          n_state = mspq_pkg::S_IDLE;
        endcase
    end

    // Output word: load on completion, drop when taken
    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        if (w_done) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mspq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_done && w_fill_we) begin
                r_fill[r_q] <= w_fill_new;
            end
        end
    end

    // Hold the request and the result words
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_type <= i_s_tuser;
            r_q    <= w_in_q;
            r_q_ok <= (32'(i_s_tdata[mspq_pkg::IDX_W-1:0]) < QUEUE_COUNT);
            r_key  <= i_s_tdata[mspq_pkg::IDX_W +: KEY_BITS];
        end
        if (w_done) begin
            r_out_key    <= n_out_key;
            r_out_status <= n_out_status;
            r_out_fill   <= n_out_fill;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {
        {(mspq_pkg::M_DATA_W - mspq_pkg::IN_KEY_W - mspq_pkg::FILL_OUT_W){1'b0}},
        mspq_pkg::t_fill_out'(r_out_fill),
        r_out_key
    };

`ifndef SYNTHESIS
    // A request taken with a free output register has its result delivered without a stall
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_accept && !r_out_valid) |-> ##2 r_out_valid)
        else $error("result not delivered two cycles after request");

    // The addressed queue never holds more than its depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mspq_pkg::S_EXEC) |-> (32'(w_cur_fill) <= QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    // An empty pop reports no entries and no key
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == mspq_pkg::ST_EMPTY)) |->
        ((r_out_fill == '0) && (r_out_key == '0)))
        else $error("empty pop with fill or key");

    // Occupied slots of the addressed queue stay in descending order
    for (genvar a = 1; a < QUEUE_DEPTH; a++) begin : g_order_chk
        assert property (@(posedge i_clk) disable iff (!i_rst_n)
            ((r_state == mspq_pkg::S_EXEC) && r_q_ok && (32'(w_cur_fill) > a)) |->
            (w_cell_key[a-1] >= w_cell_key[a]))
            else $error("queue slots out of order");
    end
`endif

endmodule

>>> src/mspq_ram.sv
module mspq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/mspq_cell.sv
module mspq_cell #(
    parameter int QUEUE_COUNT = 8,
    parameter int KEY_BITS = 64
) (
    input  logic                                     i_clk,
    input  logic [((QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1)-1:0] i_rd_addr,
    input  logic [((QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1)-1:0] i_wr_addr,
    input  mspq_pkg::t_cell_ctl                      i_ctl,
    input  logic [KEY_BITS-1:0]                      i_key,
    input  logic                                     i_prev_gt,
    input  logic [KEY_BITS-1:0]                      i_prev_key,
    output logic [KEY_BITS-1:0]                      o_key,
    output logic                                     o_gt
);

    localparam int ADDR_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

    logic [KEY_BITS-1:0] w_key;
    logic                w_wr_en;
    logic [KEY_BITS-1:0] w_wr_data;

    // This slot keeps its key when it holds a strictly larger one
    assign o_gt = i_ctl.live && (w_key > i_key);

    // Otherwise take the new key if the neighbour keeps, else its key
    assign w_wr_en   = i_ctl.push && !o_gt;
    assign w_wr_data = i_prev_gt ? i_key : i_prev_key;

    mspq_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (QUEUE_COUNT),
        .ADDR_W(ADDR_W)
    ) u_slot_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(i_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(i_rd_addr),
        .o_rd_data(w_key)
    );

    assign o_key = w_key;

endmodule
